// File: hw/rtl/sroe_pkg.sv
// Shared types and constants for the shift register output expander.
package sroe_pkg;

	localparam int CFG_W  = 4;
	localparam int OPC_W  = 2;
	localparam int NUM_W  = 7;
	localparam int BYTE_W = 8;

	localparam logic [CFG_W-1:0] CHAIN_BYTES_RST = 4'd8;

	typedef enum logic [OPC_W-1:0] {
		OP_SET       = 2'd0,
		OP_CLEAR     = 2'd1,
		OP_CLEAR_ALL = 2'd2
	} opcode_t;

	// control from the sequencer to the serialiser, one bit period
	typedef struct packed {
		logic step;
		logic load;
		logic last;
		logic pulse;
	} ser_ctrl_t;

endpackage

// File: hw/rtl/sroe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sroe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/sroe_ser.sv
// Byte serialiser: shifts a byte out MSB first and registers each result.
module sroe_ser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sroe_pkg::ser_ctrl_t           ctrl,
	input  logic [sroe_pkg::BYTE_W-1:0]   din,
	output logic                          strobe,
	output logic                          serial_bit,
	output logic                          last,
	output logic                          reset_pulse
);

	logic [sroe_pkg::BYTE_W-1:0] sh_q;
	logic                        bit_c;

	// first bit of a byte comes straight off the RAM read port
	assign bit_c = ctrl.load ? din[sroe_pkg::BYTE_W-1] : sh_q[sroe_pkg::BYTE_W-1];

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (ctrl.load) begin
				sh_q <= {din[sroe_pkg::BYTE_W-2:0], 1'b0};
			end else begin
				sh_q <= {sh_q[sroe_pkg::BYTE_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe      <= 1'b0;
			serial_bit  <= 1'b0;
			last        <= 1'b0;
			reset_pulse <= 1'b0;
		end else begin
			strobe      <= ctrl.step;
			serial_bit  <= bit_c;
			last        <= ctrl.step & ctrl.last;
			reset_pulse <= ctrl.step & ctrl.last & ctrl.pulse;
		end
	end

endmodule

// File: hw/rtl/shift_register_output_expander.sv
// Output expander top level: shadow store sequencer, RAM and serialiser.
// Sequence: a set/clear transaction passes the read, write and prime states before shifting,
// a clear-all goes straight to prime; bits then follow one per cycle, 8 per clamped chain byte.
// Busy from acceptance until the final bit is shifted, so no new request is taken meanwhile;
// this is set by the one-bit-per-cycle serialiser and the read-modify-write of the shadow RAM.
// A rejected request (bad output number or opcode) is accepted and gives nothing.
// Reset: valid flags clear, so the shadow store reads as zero; chain_bytes returns to 8.
module shift_register_output_expander #(
	parameter int MAX_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [sroe_pkg::OPC_W-1:0]   opcode,
	input  logic [sroe_pkg::NUM_W-1:0]   output_number,
	input  logic                         cfg_we,
	input  logic [sroe_pkg::CFG_W-1:0]   cfg_wdata,
	output logic                         strobe,
	output logic                         serial_bit,
	output logic                         last,
	output logic                         reset_pulse
);

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_PRIME,
		ST_SHIFT
	} state_t;

	state_t                         state_q;
	logic [sroe_pkg::CFG_W-1:0]     chain_bytes_q;
	logic [MAX_BYTES-1:0]           valid_q;
	logic                           vld_rd_q;
	logic [AW-1:0]                  idx_q;
	logic [2:0]                     bitsel_q;
	logic                           set_q;
	logic                           pulse_q;
	logic [AW-1:0]                  byte_q;
	logic [2:0]                     bit_q;

	logic [sroe_pkg::CFG_W-1:0]     bytes_c;
	logic [sroe_pkg::NUM_W-1:0]     nm1_c;
	logic                           in_range_c;
	logic                           accept_c;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [sroe_pkg::BYTE_W-1:0]    ram_wdata;
	logic                           ram_re;
	logic [AW-1:0]                  ram_raddr;
	logic [sroe_pkg::BYTE_W-1:0]    ram_rdata;
	logic [sroe_pkg::BYTE_W-1:0]    rd_byte_c;
	logic [sroe_pkg::BYTE_W-1:0]    mask_c;
	sroe_pkg::ser_ctrl_t            ser_ctrl;

	// clamp chain length into 1..MAX_BYTES
	always_comb begin
		if (chain_bytes_q == '0) begin
			bytes_c = sroe_pkg::CFG_W'(1);
		end else if (chain_bytes_q > sroe_pkg::CFG_W'(MAX_BYTES)) begin
			bytes_c = sroe_pkg::CFG_W'(MAX_BYTES);
		end else begin
			bytes_c = chain_bytes_q;
		end
	end

	assign nm1_c      = output_number - sroe_pkg::NUM_W'(1);
	assign in_range_c = (output_number != '0) &&
		(output_number <= {bytes_c[sroe_pkg::NUM_W-4:0], 3'b000});
	assign accept_c   = start && !busy;
	assign busy       = (state_q != ST_IDLE);

	// never-written or cleared entries read as zero
	assign rd_byte_c = ram_rdata & {sroe_pkg::BYTE_W{vld_rd_q}};
	assign mask_c    = sroe_pkg::BYTE_W'(1) << bitsel_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = set_q ? (rd_byte_c | mask_c) : (rd_byte_c & ~mask_c);
		ram_re    = 1'b0;
		ram_raddr = byte_q;
		ser_ctrl  = '0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q;
			end
			ST_WR: begin
				ram_we = 1'b1;
			end
			ST_PRIME: begin
				ram_re = 1'b1;
			end
			ST_SHIFT: begin
				ser_ctrl.step  = 1'b1;
				ser_ctrl.load  = (bit_q == 3'd7);
				ser_ctrl.last  = (byte_q == '0) && (bit_q == 3'd0);
				ser_ctrl.pulse = pulse_q;
				// fetch the next byte during the last bit of this one
				if (bit_q == 3'd0 && byte_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = byte_q - AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_bytes_q <= sroe_pkg::CHAIN_BYTES_RST;
		end else if (cfg_we) begin
			chain_bytes_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			idx_q    <= AW'(nm1_c[5:3]);
			bitsel_q <= nm1_c[2:0];
			set_q    <= (opcode == sroe_pkg::OP_SET);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
			pulse_q  <= 1'b0;
			byte_q   <= '0;
			bit_q    <= '0;
		end else begin
			if (ram_re) begin
				vld_rd_q <= valid_q[ram_raddr];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						byte_q <= AW'(bytes_c - sroe_pkg::CFG_W'(1));
						bit_q  <= 3'd7;
						unique case (opcode)
							sroe_pkg::OP_SET, sroe_pkg::OP_CLEAR: begin
								pulse_q <= 1'b0;
								if (in_range_c) begin
									state_q <= ST_RD;
								end
							end
							sroe_pkg::OP_CLEAR_ALL: begin
								pulse_q <= 1'b1;
								state_q <= ST_PRIME;
								for (int i = 0; i < MAX_BYTES; i++) begin
									if (sroe_pkg::CFG_W'(i) < bytes_c) begin
										valid_q[i] <= 1'b0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					valid_q[idx_q] <= 1'b1;
					state_q        <= ST_PRIME;
				end
				ST_PRIME: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (bit_q == 3'd0) begin
						if (byte_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							byte_q <= byte_q - AW'(1);
							bit_q  <= 3'd7;
						end
					end else begin
						bit_q <= bit_q - 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	sroe_ram #(
		.WIDTH(sroe_pkg::BYTE_W),
		.DEPTH(MAX_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sroe_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ser_ctrl),
		.din        (rd_byte_c),
		.strobe     (strobe),
		.serial_bit (serial_bit),
		.last       (last),
		.reset_pulse(reset_pulse)
	);

	a_strobe_from_shift: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_SHIFT))
		else $error("result strobe without a shift cycle");

	a_pulse_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		reset_pulse |-> (last && strobe))
		else $error("reset pulse off the final bit");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && byte_q == '0 && bit_q == 3'd0) |=> (state_q == ST_IDLE && last))
		else $error("run did not end on final bit");

	a_write_only_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_WR && $past(state_q) == ST_RD))
		else $error("shadow write outside read-modify-write");

endmodule
